[sv/ipc_pkg.sv]
// Shared types and constants for the infrared pulse-train capture block.
`default_nettype none

package ipc_pkg;

  // Defaults for the top-level parameters
  localparam int FRAME_ENTRIES_DEF = 64;
  localparam int TIMER_BITS_DEF    = 16;

  // Fixed field widths of the ports
  localparam int FIELD_W   = 16;
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [FIELD_W-1:0] START_THR_RST = 16'd500;
  localparam logic [FIELD_W-1:0] STOP_THR_RST  = 16'd1500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THR = 2'd0,
    CFG_STOP_THR  = 2'd1,
    CFG_LEARN     = 2'd2
  } cfg_idx_t;

  typedef logic [FIELD_W-1:0] width_t;

  // Classified capture event, as queued between front and back
  typedef struct packed {
    width_t low_width;
    width_t high_width;
    logic   start_hit;
    logic   stop_hit;
  } evt_t;

  // Frame state seen by the top level
  typedef struct packed {
    logic active;
    logic complete;
    logic count_even;
    logic count_in_range;
  } bk_status_t;

endpackage

`default_nettype wire

[sv/ipc_front.sv]
// Front part: accepts capture requests, derives widths and threshold hits.
`default_nettype none

module ipc_front #(
  parameter int TIMER_BITS = ipc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ipc_pkg::FIELD_W-1:0] in_rise_capture,
  input  wire logic [ipc_pkg::FIELD_W-1:0] in_fall_capture,
  input  wire ipc_pkg::width_t      start_thr,
  input  wire ipc_pkg::width_t      stop_thr,
  input  wire logic                 q_full,
  output logic                      q_push,
  output ipc_pkg::evt_t             q_data
);
  import ipc_pkg::*;

  localparam int CW   = TIMER_BITS;
  localparam int CMPW = (TIMER_BITS > FIELD_W) ? TIMER_BITS : FIELD_W;

  logic [CW-1:0] rise_w;
  logic [CW-1:0] fall_w;
  logic [CW-1:0] low_w;
  logic [CW-1:0] high_w;

  // Hold off the sender while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    rise_w = CW'(in_rise_capture);
    fall_w = CW'(in_fall_capture);
    low_w  = ~rise_w;
    high_w = rise_w - fall_w;

    q_data.low_width  = FIELD_W'(low_w);
    q_data.high_width = FIELD_W'(high_w);
    q_data.start_hit  = CMPW'(high_w) > CMPW'(start_thr);
    q_data.stop_hit   = CMPW'(high_w) > CMPW'(stop_thr);
  end

endmodule

`default_nettype wire

[sv/ipc_queue.sv]
// Short queue of classified events between front and back.
`default_nettype none

module ipc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ipc_pkg::evt_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output ipc_pkg::evt_t      head
);
  import ipc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  evt_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/ipc_back.sv]
// Back part: frame state update and registered result stage.
`default_nettype none

module ipc_back #(
  parameter int FRAME_ENTRIES = ipc_pkg::FRAME_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         learn_mode,
  input  wire logic                         q_not_empty,
  input  wire ipc_pkg::evt_t                q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ipc_pkg::FIELD_W-1:0]       out_low_width,
  output logic [ipc_pkg::FIELD_W-1:0]       out_high_width,
  output logic                              out_stored,
  output logic [ipc_pkg::SLOT_W-1:0]        out_slot,
  output logic                              out_started,
  output logic                              out_receiving,
  output logic                              out_frame_done,
  output ipc_pkg::bk_status_t               status
);
  import ipc_pkg::*;

  localparam int CNT_W = $clog2(FRAME_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_ROOM = CNT_W'(FRAME_ENTRIES - 2);

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             complete_r, complete_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             stored;
  logic             started;
  logic [SLOT_W-1:0] slot;

  width_t            low_width_r;
  width_t            high_width_r;
  logic              stored_r;
  logic [SLOT_W-1:0] slot_r;
  logic              started_r;

  // Advance when the result stage is empty or being drained
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    active_nxt   = active_r;
    count_nxt    = count_r;
    complete_nxt = complete_r;
    stored       = 1'b0;
    started      = 1'b0;
    slot         = '0;
    if (!active_r) begin
      if (q_head.start_hit) begin
        count_nxt  = '0;
        active_nxt = 1'b1;
        started    = 1'b1;
      end
    end else if (count_r <= LAST_ROOM) begin
      stored    = 1'b1;
      slot      = SLOT_W'(count_r);
      count_nxt = CNT_W'(count_r + CNT_W'(2));
      if ((count_nxt > LAST_ROOM) && !learn_mode) begin
        complete_nxt = 1'b1;
      end
    end
    if (q_head.stop_hit) begin
      active_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      count_r     <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        active_r   <= active_nxt;
        count_r    <= count_nxt;
        complete_r <= complete_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      low_width_r  <= q_head.low_width;
      high_width_r <= q_head.high_width;
      stored_r     <= stored;
      slot_r       <= slot;
      started_r    <= started;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_width  = low_width_r;
  assign out_high_width = high_width_r;
  assign out_stored     = stored_r;
  assign out_slot       = slot_r;
  assign out_started    = started_r;
  assign out_receiving  = active_r;
  assign out_frame_done = complete_r;

  assign status.active         = active_r;
  assign status.complete       = complete_r;
  assign status.count_even     = !count_r[0];
  assign status.count_in_range = (count_r <= CNT_W'(FRAME_ENTRIES));

endmodule

`default_nettype wire

[sv/ir_pulse_train_capture_top.sv]
// Top level of the infrared pulse-train capture block.
//
// Input channel (in_valid / in_stall): one request per capture event, carrying
// the rising and falling counter values latched by a down-counting timer.
// Result channel (out_valid / out_stall): exactly one result per request, in
// order: low and high widths, whether the pair was recorded, its even slot,
// frame start, receiving flag and the sticky frame-complete flag.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 start threshold, 1 stop threshold, 2 learn mode); write only while idle.
// Path: an accepted request is written into the queue, then popped into the
// result register, where it stays valid until taken (a stall can hold it back).
// Throughput: one request per cycle while out_stall is low, set by the
// combinational frame update in the back part; the queue absorbs a stalled
// receiver so the front keeps accepting until it fills, then in_stall rises.
// Reset (rst_n low, synchronous): thresholds go to 500 / 1500, learn mode off,
// frame idle, entry count and complete flag cleared, queue and result emptied.
// A stalled result holds its value and valid until taken.
`default_nettype none

module ir_pulse_train_capture_top #(
  parameter int FRAME_ENTRIES = ipc_pkg::FRAME_ENTRIES_DEF,
  parameter int TIMER_BITS    = ipc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ipc_pkg::FIELD_W-1:0]     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ipc_pkg::FIELD_W-1:0]     in_rise_capture,
  input  wire logic [ipc_pkg::FIELD_W-1:0]     in_fall_capture,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ipc_pkg::FIELD_W-1:0]          out_low_width,
  output logic [ipc_pkg::FIELD_W-1:0]          out_high_width,
  output logic                                 out_stored,
  output logic [ipc_pkg::SLOT_W-1:0]           out_slot,
  output logic                                 out_started,
  output logic                                 out_receiving,
  output logic                                 out_frame_done
);
  import ipc_pkg::*;

  width_t     start_thr_r;
  width_t     stop_thr_r;
  logic       learn_r;

  logic       q_full;
  logic       q_push;
  evt_t       q_in;
  logic       q_pop;
  logic       q_not_empty;
  evt_t       q_head;
  bk_status_t bk_status;

  // Configuration registers; writes to an index past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_thr_r <= START_THR_RST;
      stop_thr_r  <= STOP_THR_RST;
      learn_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_THR: start_thr_r <= cfg_wdata;
        CFG_STOP_THR:  stop_thr_r  <= cfg_wdata;
        CFG_LEARN:     learn_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: derive widths, compare against thresholds, enqueue
  ipc_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rise_capture (in_rise_capture),
    .in_fall_capture (in_fall_capture),
    .start_thr       (start_thr_r),
    .stop_thr        (stop_thr_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  // Decouple front from back so a stalled receiver does not stop intake at once
  ipc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: frame state and result register
  ipc_back #(
    .FRAME_ENTRIES (FRAME_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .learn_mode     (learn_r),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_low_width  (out_low_width),
    .out_high_width (out_high_width),
    .out_stored     (out_stored),
    .out_slot       (out_slot),
    .out_started    (out_started),
    .out_receiving  (out_receiving),
    .out_frame_done (out_frame_done),
    .status         (bk_status)
  );

  // A start event is never itself recorded
  a_start_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_started |-> !out_stored)
    else $error("start event reported as stored");

  // Complete flag is sticky until reset
  a_complete_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(bk_status.complete) |-> bk_status.complete)
    else $error("frame complete flag dropped");

  // Entry count advances by pairs and never passes the frame size
  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.count_even && bk_status.count_in_range)
    else $error("entry count odd or out of range");

  // Queue never pops while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
